// ===== hdl/hpr_pkg.sv =====
// ----------------------------------------------------------------------------
// hpr_pkg
// Shared widths, fixed-point constants, arctangent table and types of the
// holonomic pose rollout block.
// ----------------------------------------------------------------------------
package hpr_pkg;

    localparam int VEL_W      = 16;
    localparam int POS_W      = 32;
    localparam int YAW_W      = 17;
    localparam int TS_W       = 16;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 88;
    localparam int S_FIELDS_W = 2 * POS_W + YAW_W + 3 * VEL_W;
    localparam int M_FIELDS_W = 2 * POS_W + YAW_W;

    // cordic datapath
    localparam int CORDIC_ITERS = 16;
    localparam int CNT_W        = $clog2(CORDIC_ITERS);
    localparam int VW           = 34;
    localparam int ZW           = 32;
    localparam int VEL_SHIFT    = 14;
    localparam int ANG_SHIFT    = 14;

    // multiplier datapath
    localparam int MA_W = VW;
    localparam int MB_W = 32;
    localparam int PW   = MA_W + MB_W;

    localparam logic [TS_W-1:0]         TS_RESET  = 16'd6554;
    localparam logic signed [YAW_W-1:0] PI_Q      = 17'sd51472;
    localparam logic signed [YAW_W-1:0] HALF_PI_Q = 17'sd25736;
    localparam logic signed [YAW_W:0]   TWO_PI_Q  = 18'sd102944;
    localparam logic signed [YAW_W-1:0] YAW_MAX   = {1'b0, {(YAW_W-1){1'b1}}};
    localparam logic signed [YAW_W-1:0] YAW_MIN   = {1'b1, {(YAW_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [MB_W-1:0]  INV_GAIN  = 32'sd652032874;

    typedef enum logic [1:0] {
        SH_12,
        SH_24,
        SH_30
    } shift_t;

    typedef struct packed {
        logic                 done;
        logic                 busy;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
    } rot_res_t;

    // atan(2^-i) in units of 2^-28 rad
    function automatic logic signed [ZW-1:0] atan_q28(input logic [CNT_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = 32'sd210828714;
            4'd1:    v = 32'sd124459457;
            4'd2:    v = 32'sd65760959;
            4'd3:    v = 32'sd33381290;
            4'd4:    v = 32'sd16755422;
            4'd5:    v = 32'sd8385879;
            4'd6:    v = 32'sd4193963;
            4'd7:    v = 32'sd2097109;
            4'd8:    v = 32'sd1048571;
            4'd9:    v = 32'sd524287;
            4'd10:   v = 32'sd262144;
            4'd11:   v = 32'sd131072;
            4'd12:   v = 32'sd65536;
            4'd13:   v = 32'sd32768;
            4'd14:   v = 32'sd16384;
            4'd15:   v = 32'sd8192;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/holonomic_pose_rollout_top.sv =====
// ----------------------------------------------------------------------------
// holonomic_pose_rollout_top
// Forward-Euler pose rollout of a holonomic robot with a cordic rotator.
// ----------------------------------------------------------------------------
// Each s_ beat carries body-frame velocities; s_tuser marks a start beat
// that first loads an initial pose from s_tdata. Every beat advances the
// kept pose (x, y, yaw) by one step of time_step. The user is to write
// time_step on cfg_we/cfg_wdata only while the block is idle; the block
// does not enforce it. A start beat yields two m_ beats: the loaded pose
// with m_tlast low, then the stepped pose with m_tlast high. A plain beat
// yields one beat with m_tlast high. An item runs one yaw wrap, 16 cordic
// micro-rotations on the rotator, then five products through the shared
// two-stage multiplier. s_tready is high only when idle, so a new item is
// taken only once the sequencer is through with the last one.
// The result waits in an output register; the next item is accepted while
// it is stalled, but the following result holds the sequencer until m_tready
// frees the register. Synchronous reset clears the pose to zero, sets
// time_step to 6554 and clears m_tvalid and m_tlast.
// ----------------------------------------------------------------------------
module holonomic_pose_rollout_top
    import hpr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [TS_W-1:0]      cfg_wdata,      // time_step
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,        // init_x, init_y, init_yaw, vel_x, vel_y, yaw_rate
    input  logic [0:0]           s_tuser,        // start_req
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,        // pose_x, pose_y, pose_yaw
    output logic                 m_tlast         // last_of_run
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT0,
        S_WRAP,
        S_ROT0,
        S_ROT,
        S_MUL,
        S_FIN
    } state_t;

    state_t                  state_reg;
    logic [TS_W-1:0]         ts_reg;
    logic signed [POS_W-1:0] cur_x_reg, cur_y_reg;
    logic signed [YAW_W-1:0] cur_yaw_reg, q_reg;
    logic signed [VEL_W-1:0] vx_reg, vy_reg, w_reg;
    logic [2:0]              k_reg;
    logic                    m_tvalid_reg, m_tlast_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic signed [POS_W-1:0] in_x, in_y;
    logic signed [YAW_W-1:0] in_yaw, q1, q_wrap;
    logic signed [VEL_W-1:0] in_vx, in_vy, in_w;
    logic signed [YAW_W:0]   q1_e, q2_e;
    logic                    out_free;
    logic                    out_load;
    logic [M_TDATA_W-1:0]    beat;

    rot_res_t                rot;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    shift_t                  mul_sh;
    logic signed [VW-1:0]    mul_r;

    logic signed [POS_W-1:0] pos_base, pos_next;
    logic signed [POS_W+2:0] pos_sum;
    logic signed [YAW_W+4:0] yaw_sum;
    logic signed [YAW_W-1:0] yaw_next;

    assign in_x   = $signed(s_tdata[POS_W-1:0]);
    assign in_y   = $signed(s_tdata[2*POS_W-1:POS_W]);
    assign in_yaw = $signed(s_tdata[2*POS_W+YAW_W-1:2*POS_W]);
    assign in_vx  = $signed(s_tdata[2*POS_W+YAW_W+VEL_W-1:2*POS_W+YAW_W]);
    assign in_vy  = $signed(s_tdata[2*POS_W+YAW_W+2*VEL_W-1:2*POS_W+YAW_W+VEL_W]);
    assign in_w   = $signed(s_tdata[S_FIELDS_W-1:2*POS_W+YAW_W+2*VEL_W]);

    // yaw wrap by 2*pi
    always_comb begin
        q1_e   = (cur_yaw_reg > PI_Q) ? {cur_yaw_reg[YAW_W-1], cur_yaw_reg} - TWO_PI_Q
                                      : {cur_yaw_reg[YAW_W-1], cur_yaw_reg};
        q1     = q1_e[YAW_W-1:0];
        q2_e   = (q1 < -PI_Q) ? {q1[YAW_W-1], q1} + TWO_PI_Q : {q1[YAW_W-1], q1};
        q_wrap = q2_e[YAW_W-1:0];
    end

    hpr_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_ROT0),
        .vel_x   (vx_reg),
        .vel_y   (vy_reg),
        .yaw     (q_reg),
        .res     (rot)
    );

    // multiplier schedule: yaw rate, gain on x and y, then time step on both
    always_comb begin
        mul_a  = '0;
        mul_b  = MB_W'($signed({1'b0, ts_reg}));
        mul_sh = SH_12;
        if (state_reg == S_MUL) begin
            case (k_reg)
                3'd0: begin
                    mul_a = MA_W'(w_reg);
                end
                3'd1: begin
                    mul_a  = rot.x;
                    mul_b  = INV_GAIN;
                    mul_sh = SH_30;
                end
                3'd2: begin
                    mul_a  = rot.y;
                    mul_b  = INV_GAIN;
                    mul_sh = SH_30;
                end
                3'd3, 3'd4: begin
                    mul_a  = mul_r;
                    mul_sh = SH_24;
                end
                default: begin
                    mul_a = '0;
                end
            endcase
        end
    end

    hpr_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .sh   (mul_sh),
        .r    (mul_r)
    );

    // saturating accumulate
    always_comb begin
        pos_base = (k_reg == 3'd5) ? cur_x_reg : cur_y_reg;
        pos_sum  = (POS_W+3)'(pos_base) + (POS_W+3)'(mul_r);
        if (pos_sum > (POS_W+3)'(POS_MAX)) begin
            pos_next = POS_MAX;
        end else if (pos_sum < (POS_W+3)'(POS_MIN)) begin
            pos_next = POS_MIN;
        end else begin
            pos_next = pos_sum[POS_W-1:0];
        end
        yaw_sum = (YAW_W+5)'(q_reg) + (YAW_W+5)'(mul_r);
        if (yaw_sum > (YAW_W+5)'(YAW_MAX)) begin
            yaw_next = YAW_MAX;
        end else if (yaw_sum < (YAW_W+5)'(YAW_MIN)) begin
            yaw_next = YAW_MIN;
        end else begin
            yaw_next = yaw_sum[YAW_W-1:0];
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = ((state_reg == S_EMIT0) || (state_reg == S_FIN)) && out_free;
    assign beat     = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, cur_yaw_reg, cur_y_reg, cur_x_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ts_reg       <= TS_RESET;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            cur_yaw_reg  <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                ts_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        vx_reg <= in_vx;
                        vy_reg <= in_vy;
                        w_reg  <= in_w;
                        if (s_tuser[0]) begin
                            cur_x_reg   <= in_x;
                            cur_y_reg   <= in_y;
                            cur_yaw_reg <= in_yaw;
                            state_reg   <= S_EMIT0;
                        end else begin
                            state_reg <= S_WRAP;
                        end
                    end
                end
                S_EMIT0: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= 1'b0;
                        m_tdata_reg  <= beat;
                        state_reg    <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    q_reg     <= q_wrap;
                    state_reg <= S_ROT0;
                end
                S_ROT0: begin
                    state_reg <= S_ROT;
                end
                S_ROT: begin
                    if (rot.done) begin
                        k_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'd2) begin
                        cur_yaw_reg <= yaw_next;
                    end
                    if (k_reg == 3'd5) begin
                        cur_x_reg <= pos_next;
                    end
                    if (k_reg == 3'd6) begin
                        cur_y_reg <= pos_next;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= beat;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    // one item at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while an item is in flight");

    // rotator finishes only while the sequencer waits for it
    a_rot_done: assert property (@(posedge aclk) disable iff (!aresetn)
        rot.done |-> (state_reg == S_ROT))
        else $error("rotator done outside the wait state");

    // wrapped yaw stays within one half turn
    a_yaw_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROT0) |-> (q_reg <= PI_Q && q_reg >= -PI_Q))
        else $error("wrapped yaw out of range");

endmodule

// ===== hdl/hpr_cordic.sv =====
// ----------------------------------------------------------------------------
// hpr_cordic
// Iterative cordic rotator: folds the yaw into the right half plane, then
// rotates the body velocity one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module hpr_cordic
    import hpr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [VEL_W-1:0] vel_x,
    input  logic signed [VEL_W-1:0] vel_y,
    input  logic signed [YAW_W-1:0] yaw,
    output rot_res_t                res
);

    logic signed [YAW_W-1:0] zf;
    logic                    neg;
    logic signed [VW-1:0]    vx_s, vy_s, x0, y0;
    logic signed [ZW-1:0]    z0;
    logic signed [VW-1:0]    x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [ZW-1:0]    z_reg, z_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg, done_reg;

    // quadrant fold
    always_comb begin
        if (yaw > HALF_PI_Q) begin
            zf  = yaw - PI_Q;
            neg = 1'b1;
        end else if (yaw < -HALF_PI_Q) begin
            zf  = yaw + PI_Q;
            neg = 1'b1;
        end else begin
            zf  = yaw;
            neg = 1'b0;
        end
        vx_s = VW'(vel_x) <<< VEL_SHIFT;
        vy_s = VW'(vel_y) <<< VEL_SHIFT;
        x0   = neg ? -vx_s : vx_s;
        y0   = neg ? -vy_s : vy_s;
        z0   = ZW'(zf) <<< ANG_SHIFT;
    end

    // one micro-rotation
    always_comb begin
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        if (!z_reg[ZW-1]) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_q28(cnt_reg);
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_q28(cnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= x0;
                y_reg    <= y0;
                z_reg    <= z0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                z_reg   <= z_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_ITERS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.busy = busy_reg;
    assign res.x    = x_reg;
    assign res.y    = y_reg;

endmodule

// ===== hdl/hpr_mul.sv =====
// ----------------------------------------------------------------------------
// hpr_mul
// Shared two-stage signed multiplier with round-half-up right shift.
// ----------------------------------------------------------------------------
module hpr_mul
    import hpr_pkg::*;
(
    input  logic                   aclk,
    input  logic signed [MA_W-1:0] a,
    input  logic signed [MB_W-1:0] b,
    input  shift_t                 sh,
    output logic signed [VW-1:0]   r
);

    logic signed [PW-1:0] p_reg, half, rnd;
    shift_t               sh_reg;
    logic signed [VW-1:0] r_reg, r_next;

    always_comb begin
        case (sh_reg)
            SH_12:   half = PW'(1) <<< 11;
            SH_24:   half = PW'(1) <<< 23;
            SH_30:   half = PW'(1) <<< 29;
            default: half = '0;
        endcase
        rnd = p_reg + half;
        case (sh_reg)
            SH_12:   r_next = VW'(rnd >>> 12);
            SH_24:   r_next = VW'(rnd >>> 24);
            SH_30:   r_next = VW'(rnd >>> 30);
            default: r_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        p_reg  <= a * b;
        sh_reg <= sh;
        r_reg  <= r_next;
    end

    assign r = r_reg;

endmodule

// ===== dv/hpr_pose_checker.sv =====
// ----------------------------------------------------------------------------
// hpr_pose_checker
// Watches the beats of the holonomic pose rollout block, predicts every pose
// that it must emit and compares each m_ beat, all fields and m_tlast, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpr_pose_checker
    import hpr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [TS_W-1:0]      cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    output int                   mismatches,
    output int                   expected_left
);

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [YAW_W-1:0] yaw;
        logic                    last;
    } pose_beat_t;

    localparam longint PI_FX      = 51472;
    localparam longint HALF_PI_FX = 25736;
    localparam longint TWO_PI_FX  = 102944;
    localparam longint INV_K_Q30  = 652032874;
    localparam longint POS_HI     = 64'sd2147483647;
    localparam longint POS_LO     = -64'sd2147483648;
    localparam longint YAW_HI     = 65535;
    localparam longint YAW_LO     = -65536;

    logic [TS_W-1:0] step_ts;
    longint          pose_x;
    longint          pose_y;
    longint          pose_yaw;
    pose_beat_t      pose_q[$];
    int              errs;

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // atan(2^-i), 2^-28 rad
    function automatic longint arctan_step(int i);
        case (i)
            0:       return 210828714;
            1:       return 124459457;
            2:       return 65760959;
            3:       return 33381290;
            4:       return 16755422;
            5:       return 8385879;
            6:       return 4193963;
            7:       return 2097109;
            8:       return 1048571;
            9:       return 524287;
            10:      return 262144;
            11:      return 131072;
            12:      return 65536;
            13:      return 32768;
            14:      return 16384;
            default: return 8192;
        endcase
    endfunction

    function automatic void advance_pose(longint vx, longint vy, longint w);
        longint q, rx, ry, z, nx, ny, dx, dy, ts_fx;
        ts_fx = step_ts;
        q = pose_yaw;
        if (q > PI_FX) q = q - TWO_PI_FX;
        if (q < -PI_FX) q = q + TWO_PI_FX;
        rx = vx * 16384;
        ry = vy * 16384;
        z  = q;
        // fold into the right half plane, negate the vector
        if (z > HALF_PI_FX) begin
            z  = z - PI_FX;
            rx = -rx;
            ry = -ry;
        end else if (z < -HALF_PI_FX) begin
            z  = z + PI_FX;
            rx = -rx;
            ry = -ry;
        end
        z = z * 16384;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = rx - (ry >>> i);
                ny = ry + (rx >>> i);
                z  = z - arctan_step(i);
            end else begin
                nx = rx + (ry >>> i);
                ny = ry - (rx >>> i);
                z  = z + arctan_step(i);
            end
            rx = nx;
            ry = ny;
        end
        rx = round_shift(rx * INV_K_Q30, 30);
        ry = round_shift(ry * INV_K_Q30, 30);
        dx = round_shift(rx * ts_fx, 24);
        dy = round_shift(ry * ts_fx, 24);
        pose_x   = clamp(pose_x + dx, POS_LO, POS_HI);
        pose_y   = clamp(pose_y + dy, POS_LO, POS_HI);
        pose_yaw = clamp(q + round_shift(w * ts_fx, 12), YAW_LO, YAW_HI);
    endfunction

    function automatic pose_beat_t pose_now(logic last);
        pose_beat_t r;
        r.x    = pose_x[POS_W-1:0];
        r.y    = pose_y[POS_W-1:0];
        r.yaw  = pose_yaw[YAW_W-1:0];
        r.last = last;
        return r;
    endfunction

    always @(posedge aclk) begin
        pose_beat_t want;
        pose_beat_t seen;
        if (!aresetn) begin
            step_ts  = 16'd6554;
            pose_x   = 0;
            pose_y   = 0;
            pose_yaw = 0;
            pose_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen = {m_tdata[31:0], m_tdata[63:32], m_tdata[80:64], m_tlast};
                if (pose_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected pose beat: x=%0d y=%0d yaw=%0d last=%0b",
                                 seen.x, seen.y, seen.yaw, seen.last);
                end else begin
                    want = pose_q.pop_front();
                    if (seen !== want) begin
                        errs++;
                        if (errs <= 10)
                            $display("pose mismatch: exp x=%0d y=%0d yaw=%0d last=%0b,",
                                     want.x, want.y, want.yaw, want.last,
                                     " got x=%0d y=%0d yaw=%0d last=%0b",
                                     seen.x, seen.y, seen.yaw, seen.last);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0]) begin
                    pose_x   = longint'($signed(s_tdata[31:0]));
                    pose_y   = longint'($signed(s_tdata[63:32]));
                    pose_yaw = longint'($signed(s_tdata[80:64]));
                    pose_q   = {pose_q, pose_now(1'b0)};
                end
                advance_pose(longint'($signed(s_tdata[96:81])),
                             longint'($signed(s_tdata[112:97])),
                             longint'($signed(s_tdata[128:113])));
                pose_q = {pose_q, pose_now(1'b1)};
            end
            if (cfg_we) step_ts = cfg_wdata;
        end
        mismatches    <= errs;
        expected_left <= pose_q.size();
    end

endmodule

// ===== dv/holonomic_pose_rollout_top_tb.sv =====
// ----------------------------------------------------------------------------
// holonomic_pose_rollout_top_tb
// Drives start and plain velocity beats through the pose rollout block under
// several time steps and idle patterns, with a long output hold-off, while
// hpr_pose_checker predicts and checks every pose beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module holonomic_pose_rollout_top_tb;
    import hpr_pkg::*;

    localparam logic [VEL_W-1:0] VEL_MAX = 16'h7fff;
    localparam logic [VEL_W-1:0] VEL_MIN = 16'h8000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [TS_W-1:0]      cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    int                   mismatches;
    int                   expected_left;

    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic hold_req  = 1'b0;
    logic rx_hold   = 1'b0;

    holonomic_pose_rollout_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    hpr_pose_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    // long output hold-off so the block backs up into its input
    initial begin
        wait (hold_req);
        repeat (400) begin
            @(posedge aclk);
            rx_hold <= 1'b1;
        end
        @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_beat(input logic start, input logic [POS_W-1:0] ix,
                             input logic [POS_W-1:0] iy, input logic [YAW_W-1:0] iyaw,
                             input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy,
                             input logic [VEL_W-1:0] w);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {7'b0, w, vy, vx, iyaw, iy, ix};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [VEL_W-1:0] rand_vel();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) return VEL_W'($urandom);
        if (pick < 9) return VEL_W'(int'($urandom_range(4000)) - 2000);
        case ($urandom_range(2))
            0:       return VEL_MAX;
            1:       return VEL_MIN;
            default: return '0;
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_beat($urandom_range(99) < 15, $urandom, $urandom,
                      YAW_W'($urandom_range(131071)), rand_vel(), rand_vel(), rand_vel());
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
            waited++;
        end while (expected_left != 0 && waited < 200000);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_step(input logic [TS_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed beats at the reset time step
        send_beat(1, 0, 0, 0, VEL_MAX, 0, 0);
        send_beat(0, 0, 0, 0, 0, VEL_MAX, VEL_MAX);
        send_beat(1, POS_MAX, POS_MIN, YAW_MAX, VEL_MIN, VEL_MIN, VEL_MIN);
        send_beat(1, POS_MIN, POS_MAX, YAW_MIN, VEL_MAX, VEL_MAX, VEL_MAX);
        send_beat(1, 100, -100, PI_Q, 1000, -700, 300);
        send_beat(1, 100, -100, -PI_Q, 1000, -700, 300);
        send_beat(1, 100, -100, PI_Q + 1, 1000, -700, 300);
        send_beat(1, 100, -100, -PI_Q - 1, 1000, -700, 300);
        send_beat(1, 100, -100, HALF_PI_Q, 1000, -700, 300);
        send_beat(1, 100, -100, HALF_PI_Q + 1, 1000, -700, 300);
        send_beat(1, 100, -100, -HALF_PI_Q, 1000, -700, 300);
        send_beat(1, 100, -100, -HALF_PI_Q - 1, 1000, -700, 300);
        send_beat(1, POS_MAX - 1000, 0, 0, VEL_MAX, 0, 0);
        send_beat(1, POS_MIN + 5, POS_MIN + 5, PI_Q, VEL_MAX, VEL_MAX, 0);
        send_beat(1, 0, 0, 51000, 0, 0, VEL_MAX);
        send_beat(0, 0, 0, 0, 0, 0, VEL_MAX);
        send_beat(1, 0, 0, -51000, 0, 0, VEL_MIN);
        send_beat(0, 0, 0, 0, VEL_MIN, VEL_MAX, VEL_MIN);
        send_beat(0, 0, 0, 0, 16'hffff, 1, 16'hffff);
        send_beat(0, 0, 0, 0, 0, 0, 0);
        settle();

        set_step(1);
        send_random(60);
        settle();

        set_step(16'hffff);
        idle_pct = 71;
        send_random(80);
        settle();

        // zero step: yaw still wraps, position holds
        set_step(0);
        idle_pct  = 0;
        stall_pct = 71;
        send_beat(1, 12345, -54321, YAW_MAX, VEL_MAX, VEL_MIN, VEL_MAX);
        send_beat(0, 0, 0, 0, VEL_MIN, VEL_MAX, VEL_MIN);
        send_random(40);
        settle();

        set_step($urandom);
        idle_pct = 18;
        stall_pct = 18;
        send_random(100);
        settle();

        set_step(16'd6554);
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        send_random(8);
        settle();

        set_step($urandom);
        idle_pct  = 0;
        stall_pct = 0;
        send_random(50);
        idle_pct = 71;
        stall_pct = 71;
        send_random(50);
        idle_pct  = 0;
        stall_pct = 0;
        send_random(50);
        settle();

        if (mismatches == 0 && expected_left == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
